[sv/length_prefixed_request_deframer_assert.svh]
// Assertion shorthands shared by the deframer modules.
// Both expect signals named clk and rst_n in the enclosing module.
`ifndef LENGTH_PREFIXED_REQUEST_DEFRAMER_ASSERT_SVH
`define LENGTH_PREFIXED_REQUEST_DEFRAMER_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define LPRD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define LPRD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/lprd_pkg.sv]
package lprd_pkg;

  // Width of the argument index counter (saturates at all ones)
  localparam int unsigned ARG_INDEX_WIDTH = 18;
  localparam int unsigned MAX_ARGS_W      = 18;
  localparam int unsigned CFG_ADDR_W      = 3;
  localparam int unsigned CFG_DATA_W      = 32;

  // Register reset values
  localparam logic [31:0]         MAX_MSG_LEN_RESET = 32'd33554432;
  localparam logic [MAX_ARGS_W-1:0] MAX_ARGS_RESET  = 18'd200000;

  // Register select (paddr bit 2)
  localparam logic REG_MAX_MESSAGE_LENGTH = 1'b0;
  localparam logic REG_MAX_ARGUMENTS      = 1'b1;

  typedef enum logic [2:0] {
    PH_HDR   = 3'd0,
    PH_COUNT = 3'd1,
    PH_ALEN  = 3'd2,
    PH_DATA  = 3'd3,
    PH_TAIL  = 3'd4,
    PH_ERR   = 3'd5
  } phase_t;

  typedef enum logic [2:0] {
    KIND_MSG_LEN   = 3'd0,
    KIND_ARG_COUNT = 3'd1,
    KIND_ARG_LEN   = 3'd2,
    KIND_ARG_DATA  = 3'd3,
    KIND_DROPPED   = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    ERR_NONE      = 2'd0,
    ERR_TOO_LONG  = 2'd1,
    ERR_MALFORMED = 2'd2
  } err_t;

  typedef struct packed {
    logic [31:0]           max_message_length;
    logic [MAX_ARGS_W-1:0] max_arguments;
  } cfg_t;

  typedef struct packed {
    logic [7:0]                 echo_byte;
    kind_t                      byte_kind;
    logic [ARG_INDEX_WIDTH-1:0] arg_index;
    logic                       arg_last;
    logic                       arg_empty;
    logic                       message_last;
    err_t                       error_code;
  } result_t;

endpackage

[sv/length_prefixed_request_deframer.sv]
// Length-prefixed request deframer.
// Input channel: one request byte per item (in_valid / in_stall). Result channel:
// one label per byte (out_valid / out_stall) giving the echoed byte, its kind,
// the argument index and the argument-end, empty-argument and message-end flags,
// plus an error code. Limits are set through the APB-style port: max message
// length at byte address 0, max argument count at address 4.
// Each accepted byte's label is registered into the output register, or
// into the skid entry while it is held. Throughput: one byte per cycle while
// in_stall is low; the parse state is a handful of counters updated per byte.
// Stalling: the result side holds two labels (output register plus skid entry).
// in_stall goes high only while both are occupied, so one extra byte is taken
// after out_stall rises and nothing is lost.
// Reset: parse state returns to waiting for a message length, the sticky error
// clears, both limits return to their defaults and the output buffer empties.
// After any framing error every further byte is dropped with the error code
// until reset.
`include "length_prefixed_request_deframer_assert.svh"

module length_prefixed_request_deframer import lprd_pkg::*; (
  input  logic                       clk,
  input  logic                       rst_n,
  // request bytes
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [7:0]                 in_byte_value,
  // labelled bytes
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [7:0]                 out_echo_byte,
  output logic [2:0]                 out_byte_kind,
  output logic [ARG_INDEX_WIDTH-1:0] out_arg_index,
  output logic                       out_arg_last,
  output logic                       out_arg_empty,
  output logic                       out_message_last,
  output logic [1:0]                 out_error_code,
  // configuration
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [CFG_ADDR_W-1:0]      paddr,
  input  logic [CFG_DATA_W-1:0]      pwdata,
  output logic [CFG_DATA_W-1:0]      prdata,
  output logic                       pready
);

  cfg_t    cfg_r, cfg_nxt;
  result_t result;
  result_t out_r, out_nxt;
  result_t skid_r, skid_nxt;
  logic    out_valid_r, out_valid_nxt;
  logic    skid_valid_r, skid_valid_nxt;
  logic    accept;
  logic    out_take;
  logic    cfg_write;

  // Configuration registers
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_write) begin
      case (paddr[2])
        REG_MAX_MESSAGE_LENGTH: cfg_nxt.max_message_length = pwdata;
        REG_MAX_ARGUMENTS:      cfg_nxt.max_arguments      = pwdata[MAX_ARGS_W-1:0];
        default:                cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_MAX_MESSAGE_LENGTH: prdata = cfg_r.max_message_length;
      REG_MAX_ARGUMENTS:      prdata = CFG_DATA_W'(cfg_r.max_arguments);
      default:                prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_message_length <= MAX_MSG_LEN_RESET;
      cfg_r.max_arguments      <= MAX_ARGS_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Handshakes
  assign in_stall = skid_valid_r;
  assign accept   = in_valid && !skid_valid_r;
  assign out_take = out_valid_r && !out_stall;

  lprd_parser u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .byte_value (in_byte_value),
    .cfg        (cfg_r),
    .result     (result)
  );

  // Output register with one skid entry
  always_comb begin
    out_nxt        = out_r;
    skid_nxt       = skid_r;
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    if (!out_valid_r || out_take) begin
      if (skid_valid_r) begin
        out_nxt        = skid_r;
        out_valid_nxt  = 1'b1;
        skid_valid_nxt = 1'b0;
      end else begin
        out_nxt       = result;
        out_valid_nxt = accept;
      end
    end else if (accept) begin
      skid_nxt       = result;
      skid_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_echo_byte    = out_r.echo_byte;
  assign out_byte_kind    = out_r.byte_kind;
  assign out_arg_index    = out_r.arg_index;
  assign out_arg_last     = out_r.arg_last;
  assign out_arg_empty    = out_r.arg_empty;
  assign out_message_last = out_r.message_last;
  assign out_error_code   = out_r.error_code;

  `LPRD_ASSERT_NOW(a_skid_behind_out, skid_valid_r, out_valid_r,
    "skid entry held with empty output register")
  `LPRD_ASSERT_NOW(a_skid_fills_on_stall, $rose(skid_valid_r), $past(out_stall),
    "skid entry filled without a stalled output")
  `LPRD_ASSERT_NEXT(a_skid_drains_to_out, skid_valid_r, out_valid_r,
    "output went empty while skid entry was held")

endmodule

[sv/lprd_parser.sv]
`include "length_prefixed_request_deframer_assert.svh"

module lprd_parser import lprd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       accept,
  input  logic [7:0] byte_value,
  input  cfg_t       cfg,
  output result_t    result
);

  phase_t                     phase_r, phase_nxt;
  logic [1:0]                 wbc_r, wbc_nxt;
  logic [23:0]                wa_r, wa_nxt;
  logic [31:0]                mbl_r, mbl_nxt;
  logic [MAX_ARGS_W-1:0]      args_left_r, args_left_nxt;
  logic [ARG_INDEX_WIDTH-1:0] cur_arg_r, cur_arg_nxt;
  logic [31:0]                abl_r, abl_nxt;
  logic                       malformed_r, malformed_nxt;
  err_t                       sticky_r, sticky_nxt;

  // Word assembly: little-endian, four bytes to a word
  logic        word_done;
  logic [31:0] word_full;
  logic [23:0] wa_fill;
  logic [2:0]  word_cnt_hi;

  assign word_done   = (wbc_r == 2'd3);
  assign word_full   = {byte_value, wa_r};
  assign word_cnt_hi = 3'(word_full[31:MAX_ARGS_W] != '0);

  always_comb begin
    wa_fill = wa_r;
    case (wbc_r)
      2'd0:    wa_fill[7:0]   = byte_value;
      2'd1:    wa_fill[15:8]  = byte_value;
      2'd2:    wa_fill[23:16] = byte_value;
      default: wa_fill        = '0;
    endcase
  end

  // Next state and the label for the accepted byte
  always_comb begin
    phase_nxt     = phase_r;
    wbc_nxt       = wbc_r;
    wa_nxt        = wa_r;
    mbl_nxt       = mbl_r;
    args_left_nxt = args_left_r;
    cur_arg_nxt   = cur_arg_r;
    abl_nxt       = abl_r;
    malformed_nxt = malformed_r;
    sticky_nxt    = sticky_r;

    result              = '0;
    result.echo_byte    = byte_value;
    result.byte_kind    = KIND_DROPPED;
    result.error_code   = ERR_NONE;

    if (accept) begin
      if (phase_r == PH_ERR) begin
        result.error_code = sticky_r;
      end else if (phase_r == PH_HDR) begin
        result.byte_kind = KIND_MSG_LEN;
        wbc_nxt = wbc_r + 2'd1;
        wa_nxt  = wa_fill;
        if (word_done) begin
          if (word_full > cfg.max_message_length) begin
            result.error_code = ERR_TOO_LONG;
            sticky_nxt        = ERR_TOO_LONG;
            phase_nxt         = PH_ERR;
          end else if (word_full == '0) begin
            result.message_last = 1'b1;
            result.error_code   = ERR_MALFORMED;
            sticky_nxt          = ERR_MALFORMED;
            phase_nxt           = PH_ERR;
          end else begin
            mbl_nxt       = word_full;
            cur_arg_nxt   = '0;
            malformed_nxt = 1'b0;
            phase_nxt     = PH_COUNT;
          end
        end
      end else begin
        mbl_nxt = mbl_r - 32'd1;
        if (!malformed_r) begin
          case (phase_r)
            PH_COUNT: begin
              result.byte_kind = KIND_ARG_COUNT;
              wbc_nxt = wbc_r + 2'd1;
              wa_nxt  = wa_fill;
              if (word_done) begin
                args_left_nxt = word_full[MAX_ARGS_W-1:0];
                cur_arg_nxt   = '0;
                if (word_cnt_hi != 3'd0 ||
                    word_full[MAX_ARGS_W-1:0] > cfg.max_arguments) begin
                  malformed_nxt = 1'b1;
                end else if (word_full == '0) begin
                  phase_nxt = PH_TAIL;
                end else begin
                  phase_nxt = PH_ALEN;
                end
              end
            end
            PH_ALEN: begin
              result.byte_kind = KIND_ARG_LEN;
              result.arg_index = cur_arg_r;
              wbc_nxt = wbc_r + 2'd1;
              wa_nxt  = wa_fill;
              if (word_done) begin
                abl_nxt = word_full;
                if (word_full == '0) begin
                  // zero-length argument ends on its length bytes
                  result.arg_empty = 1'b1;
                  args_left_nxt    = args_left_r - MAX_ARGS_W'(1);
                  if (cur_arg_r != '1) cur_arg_nxt = cur_arg_r + ARG_INDEX_WIDTH'(1);
                  phase_nxt = (args_left_r == MAX_ARGS_W'(1)) ? PH_TAIL : PH_ALEN;
                end else begin
                  phase_nxt = PH_DATA;
                end
              end
            end
            PH_DATA: begin
              result.byte_kind = KIND_ARG_DATA;
              result.arg_index = cur_arg_r;
              abl_nxt = abl_r - 32'd1;
              if (abl_r == 32'd1) begin
                result.arg_last = 1'b1;
                args_left_nxt   = args_left_r - MAX_ARGS_W'(1);
                if (cur_arg_r != '1) cur_arg_nxt = cur_arg_r + ARG_INDEX_WIDTH'(1);
                phase_nxt = (args_left_r == MAX_ARGS_W'(1)) ? PH_TAIL : PH_ALEN;
              end
            end
            default: begin
              // bytes after the last argument
              malformed_nxt = 1'b1;
            end
          endcase
        end

        // Last body byte: close the message or fail it
        if (mbl_r == 32'd1) begin
          result.message_last = 1'b1;
          if (malformed_nxt || phase_nxt != PH_TAIL) begin
            result.error_code = ERR_MALFORMED;
            sticky_nxt        = ERR_MALFORMED;
            phase_nxt         = PH_ERR;
          end else begin
            phase_nxt     = PH_HDR;
            wbc_nxt       = '0;
            wa_nxt        = '0;
            cur_arg_nxt   = '0;
            args_left_nxt = '0;
            abl_nxt       = '0;
            malformed_nxt = 1'b0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_HDR;
      wbc_r       <= '0;
      wa_r        <= '0;
      mbl_r       <= '0;
      args_left_r <= '0;
      cur_arg_r   <= '0;
      abl_r       <= '0;
      malformed_r <= 1'b0;
      sticky_r    <= ERR_NONE;
    end else begin
      phase_r     <= phase_nxt;
      wbc_r       <= wbc_nxt;
      wa_r        <= wa_nxt;
      mbl_r       <= mbl_nxt;
      args_left_r <= args_left_nxt;
      cur_arg_r   <= cur_arg_nxt;
      abl_r       <= abl_nxt;
      malformed_r <= malformed_nxt;
      sticky_r    <= sticky_nxt;
    end
  end

  `LPRD_ASSERT_NOW(a_err_phase_matches_sticky, 1'b1,
    (phase_r == PH_ERR) == (sticky_r != ERR_NONE), "error phase and sticky code disagree")
  `LPRD_ASSERT_NEXT(a_sticky_holds, sticky_r != ERR_NONE,
    $stable(sticky_r), "sticky error changed")
  `LPRD_ASSERT_NOW(a_body_has_bytes_left,
    phase_r == PH_COUNT || phase_r == PH_ALEN || phase_r == PH_DATA || phase_r == PH_TAIL,
    mbl_r != 32'd0, "in message body with no bytes left")

endmodule
